[src/sha256_pkg.sv]
package sha256_pkg;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic [1:0] CMD_BYTE        = 2'd0;
	localparam logic [1:0] CMD_BYTE_FINISH = 2'd1;
	localparam logic [1:0] CMD_FINISH      = 2'd2;
	localparam logic [1:0] CMD_NONE        = 2'd3;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

[src/sha256_round.sv]
// one compression round per cycle while step is high, over a 16-word rolling schedule window
module sha256_round
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        load,      // copy chain into working vars
	input  logic        step,      // run one round
	input  logic        word_wr,   // shift a message word into the window
	input  logic [31:0] word_in,
	input  logic [5:0]  round,
	input  logic [31:0] chain [8],
	output logic [31:0] vars [8]
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] w_cur, w_next, s0, s1, e, a, big0, big1, ch, maj, t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		w_cur  = w_q[0];
		s0     = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1     = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_next = s1 + w_q[9] + s0 + w_q[0];
		e      = v_q[4];
		a      = v_q[0];
		big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		ch     = (e & v_q[5]) ^ (~e & v_q[6]);
		t1     = v_q[7] + big1 + ch + ROUND_K[round] + w_cur;
		big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		maj    = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2     = big0 + maj;
	end

	always_ff @(posedge clk) begin
		if (word_wr) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= word_in;
		end else if (step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_next;
		end
		if (load) begin
			v_q <= chain;
		end else if (step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;

endmodule

[src/sha256_message_hash.sv]
// byte beat: the block stays in IDLE, ready for the next byte, when the byte does not complete a block
// a byte that completes a block holds the input off through its steps: accept, 64 rounds, one fold
// finish: padding bytes one per cycle, with 64 rounds and a fold per filled block, then eight output beats
// sustained byte rate is set by the one-round-per-cycle unit: no byte is taken while a block runs its rounds and fold
// arst_n loads the initial hash values and clears the byte count
module sha256_message_hash
	import sha256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	typedef enum logic [2:0] {IDLE, ROUNDS, FOLD, PAD, EMIT} state_t;

	state_t      state_q;
	logic [60:0] total_q;
	logic [63:0] bits_q;
	logic [31:0] chain_q [8];
	logic [23:0] part_q;
	logic [5:0]  round_q;
	logic        fin_q;      // finishing: padding / emitting pending
	logic        pad_one_q;  // 0x80 already appended
	logic        last_blk_q; // current block carries the length field
	logic [2:0]  idx_q;
	logic [31:0] vars [8];

	logic        byte_en, load, step, word_wr;
	logic [7:0]  byte_val;
	logic [31:0] word_in;
	logic [5:0]  fill;

	assign fill     = total_q[5:0];
	assign in_ready = (state_q == IDLE);
	assign word_in  = {part_q, byte_val};
	assign word_wr  = byte_en && (fill[1:0] == 2'b11);
	assign load     = byte_en && (fill == 6'd63);
	assign step     = (state_q == ROUNDS);

	always_comb begin
		byte_en  = 1'b0;
		byte_val = 8'h00;
		if (state_q == IDLE && in_valid) begin
			byte_en  = (in_data.cmd == CMD_BYTE) || (in_data.cmd == CMD_BYTE_FINISH);
			byte_val = in_data.data_byte;
		end else if (state_q == PAD) begin
			byte_en = 1'b1;
			if (!pad_one_q) byte_val = PAD_BYTE;
			else if (last_blk_q && fill >= LEN_START) byte_val = bits_q[8*(63 - fill) +: 8];
		end
	end

	sha256_round u_round (
		.clk(clk), .load(load), .step(step),
		.word_wr(word_wr), .word_in(word_in), .round(round_q),
		.chain(chain_q), .vars(vars)
	);

	always_ff @(posedge clk) begin
		if (byte_en) part_q <= {part_q[15:0], byte_val};
	end

	assign out_valid            = (state_q == EMIT);
	assign out_data.digest_word = chain_q[idx_q];
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			total_q    <= '0;
			bits_q     <= '0;
			chain_q    <= INIT_H;
			round_q    <= '0;
			fin_q      <= 1'b0;
			pad_one_q  <= 1'b0;
			last_blk_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (byte_en) total_q <= total_q + 61'd1;
			unique case (state_q)
				IDLE: begin
					if (in_valid && in_data.cmd != CMD_NONE) begin
						fin_q <= (in_data.cmd != CMD_BYTE);
						// length of the message including this beat's byte
						bits_q <= {total_q + {60'd0, byte_en}, 3'b000};
						pad_one_q  <= 1'b0;
						last_blk_q <= 1'b0;
						if (load) state_q <= ROUNDS;
						else if (in_data.cmd != CMD_BYTE) state_q <= PAD;
					end
				end
				PAD: begin
					pad_one_q <= 1'b1;
					// 0x80 before the length slot: length goes in this same block
					if (!pad_one_q && fill < LEN_START) last_blk_q <= 1'b1;
					if (load) state_q <= ROUNDS;
				end
				ROUNDS: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= FOLD;
				end
				FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
					if (!fin_q) state_q <= IDLE;
					else if (last_blk_q) state_q <= EMIT;
					else begin
						if (pad_one_q) last_blk_q <= 1'b1;
						state_q <= PAD;
					end
				end
				EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= IDLE;
							chain_q <= INIT_H;
							total_q <= '0;
							fin_q   <= 1'b0;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
